[hdl/alpha_blend_region_defines.svh]
// ----------------------------------------------------------------------------
// alpha_blend_region_defines
// Assertion macros shared by the alpha blend region block.
// ----------------------------------------------------------------------------
`ifndef ALPHA_BLEND_REGION_DEFINES_SVH
`define ALPHA_BLEND_REGION_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ABR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ABR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/abr_pkg.sv]
// ----------------------------------------------------------------------------
// abr_pkg
// Types and constants of the alpha blend region pixel engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package abr_pkg;

  // Configuration register indexes
  typedef enum logic [3:0] {
    CFG_SHAPE    = 4'd0,
    CFG_ORIGIN_X = 4'd1,
    CFG_ORIGIN_Y = 4'd2,
    CFG_EXTENT_W = 4'd3,
    CFG_EXTENT_H = 4'd4,
    CFG_RADIUS   = 4'd5,
    CFG_FILL     = 4'd6,
    CFG_ALPHA    = 4'd7
  } cfg_idx_e;

  typedef enum logic {
    SHAPE_RECT = 1'b0,
    SHAPE_DISC = 1'b1
  } shape_e;

  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned CoordW   = 12;
  localparam int unsigned PixelW   = 32;

  localparam logic [7:0]  Opaque      = 8'hFF;
  localparam logic [7:0]  MixMax      = 8'd255;
  localparam logic [15:0] MixRound    = 16'd127;
  // x / 255 == (x * DivRecip) >> DivShift for every x below 2^16
  localparam logic [15:0] DivRecip    = 16'd32897;
  localparam int unsigned DivShift    = 23;

  typedef struct packed {
    shape_e              shape;
    logic signed [13:0]  origin_x;
    logic signed [13:0]  origin_y;
    logic [12:0]         extent_w;
    logic [12:0]         extent_h;
    logic [11:0]         radius;
    logic [23:0]         fill_color;
    logic [7:0]          alpha;
  } cfg_t;

  // Load enables of the three pipeline stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  typedef struct packed {
    logic [2:0] vld;
  } pipe_stat_t;

endpackage

[hdl/abr_stream_if.sv]
// ----------------------------------------------------------------------------
// abr_stream_if
// Valid/ready channels of the pixel engine: canvas pixels in, results out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface abr_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] pix_x;
  logic [11:0] pix_y;
  logic [31:0] old_pixel;

  modport source (output valid, output pix_x, output pix_y, output old_pixel, input ready);
  modport sink   (input valid, input pix_x, input pix_y, input old_pixel, output ready);
endinterface

interface abr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] new_pixel;
  logic        covered;

  modport source (output valid, output new_pixel, output covered, input ready);
  modport sink   (input valid, input new_pixel, input covered, output ready);
endinterface

[hdl/abr_pipe_ctrl.sv]
// ----------------------------------------------------------------------------
// abr_pipe_ctrl
// Valid bits and stage enables of the three-stage pixel pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module abr_pipe_ctrl import abr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output stage_en_t  en_o,
  output pipe_stat_t stat_o
);

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  // a stage loads when it is empty or its content moves on
  assign rdy3 = !v3_q || out_ready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  assign in_ready_o  = rdy1;
  assign out_valid_o = v3_q;
  assign en_o        = '{s1: rdy1, s2: rdy2, s3: rdy3};
  assign stat_o.vld  = {v3_q, v2_q, v1_q};

endmodule

[hdl/abr_region.sv]
// ----------------------------------------------------------------------------
// abr_region
// Region test: offsets and rectangle compare, then squares, then disc compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module abr_region import abr_pkg::*; #(
  parameter int unsigned CANVAS_WIDTH  = 4096,
  parameter int unsigned CANVAS_HEIGHT = 4096
) (
  input  logic             clk_i,
  input  stage_en_t        en_i,
  input  cfg_t             cfg_i,
  input  logic [CoordW-1:0] pix_x_i,
  input  logic [CoordW-1:0] pix_y_i,
  output logic             hit_o
);

  localparam logic [13:0] CanvasW = 14'(CANVAS_WIDTH);
  localparam logic [13:0] CanvasH = 14'(CANVAS_HEIGHT);

  logic signed [14:0] dx, dy;
  logic [13:0]        dxa, dya;
  logic               on_canvas, in_rect;

  logic [13:0] dxa_q, dya_q;
  logic        on_q, rect_q, disc_q;
  logic [27:0] xsq_q, ysq_q;
  logic [23:0] rsq_q;
  logic        on2_q, rect2_q, disc2_q;
  logic [28:0] dsq;

  // stage 1: offsets from the origin, rectangle and canvas compares
  assign dx  = $signed({3'b000, pix_x_i}) - $signed({cfg_i.origin_x[13], cfg_i.origin_x});
  assign dy  = $signed({3'b000, pix_y_i}) - $signed({cfg_i.origin_y[13], cfg_i.origin_y});
  assign dxa = dx[14] ? 14'(-dx) : dx[13:0];
  assign dya = dy[14] ? 14'(-dy) : dy[13:0];

  assign on_canvas = ({2'b00, pix_x_i} < CanvasW) && ({2'b00, pix_y_i} < CanvasH);
  assign in_rect   = !dx[14] && (dx[13:0] < {1'b0, cfg_i.extent_w})
                  && !dy[14] && (dy[13:0] < {1'b0, cfg_i.extent_h});

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      dxa_q  <= dxa;
      dya_q  <= dya;
      on_q   <= on_canvas;
      rect_q <= on_canvas && in_rect;
      disc_q <= (cfg_i.shape == SHAPE_DISC);
    end
  end

  // stage 2: squared distances and squared radius
  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      xsq_q   <= dxa_q * dxa_q;
      ysq_q   <= dya_q * dya_q;
      rsq_q   <= cfg_i.radius * cfg_i.radius;
      on2_q   <= on_q;
      rect2_q <= rect_q;
      disc2_q <= disc_q;
    end
  end

  // into stage 3: disc compare and shape select
  assign dsq   = {1'b0, xsq_q} + {1'b0, ysq_q};
  assign hit_o = disc2_q ? (on2_q && (dsq <= {5'b00000, rsq_q})) : rect2_q;

endmodule

[hdl/abr_blend.sv]
// ----------------------------------------------------------------------------
// abr_blend
// Color path: per-channel weighted sum, divide by 255, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module abr_blend import abr_pkg::*; (
  input  logic              clk_i,
  input  stage_en_t         en_i,
  input  cfg_t              cfg_i,
  input  logic [PixelW-1:0] old_pixel_i,
  input  logic              hit_i,
  output logic [PixelW-1:0] new_pixel_o,
  output logic              covered_o
);

  logic [PixelW-1:0] old1_q, old2_q;
  logic [15:0]       mix_q [3];
  logic [7:0]        quo   [3];
  logic [7:0]        inv_alpha;
  logic [PixelW-1:0] new_pixel_q;
  logic              covered_q;

  assign inv_alpha = MixMax - cfg_i.alpha;

  always_ff @(posedge clk_i) begin
    if (en_i.s1) old1_q <= old_pixel_i;
    if (en_i.s2) old2_q <= old1_q;
  end

  // channel 0 is blue, 2 is red
  for (genvar c = 0; c < 3; c++) begin : g_chan
    logic [31:0] prod;

    always_ff @(posedge clk_i) begin
      if (en_i.s2) begin
        mix_q[c] <= {8'h00, old1_q[c*8 +: 8]} * {8'h00, inv_alpha}
                  + {8'h00, cfg_i.fill_color[c*8 +: 8]} * {8'h00, cfg_i.alpha}
                  + MixRound;
      end
    end

    assign prod   = {16'h0000, mix_q[c]} * {16'h0000, DivRecip};
    assign quo[c] = prod[DivShift +: 8];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      new_pixel_q <= hit_i ? {Opaque, quo[2], quo[1], quo[0]} : old2_q;
      covered_q   <= hit_i;
    end
  end

  assign new_pixel_o = new_pixel_q;
  assign covered_o   = covered_q;

endmodule

[hdl/alpha_blend_region.sv]
// ----------------------------------------------------------------------------
// alpha_blend_region
// Streaming region alpha blend over RGB888 canvas pixels.
// ----------------------------------------------------------------------------
//  channel   | dir | payload                         | handshake
//  px_in_i   | in  | pix_x, pix_y, old_pixel         | valid / ready
//  px_out_o  | out | new_pixel, covered              | valid / ready
//  cfg       | in  | cfg_idx_i, cfg_wdata_i          | cfg_we_i, no back-pressure
//
//  One pixel per cycle is taken while ready is high; each result passes
//  through the three register stages (offsets, multipliers, divide-by-255
//  and result register) before it is offered on the output.
//  Reset clears the valid bits and all configuration registers to zero.
//  A stalled output holds its result; upstream stages keep filling bubbles
//  and ready drops only when all three stages hold pixels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "alpha_blend_region_defines.svh"

module alpha_blend_region import abr_pkg::*; #(
  parameter int unsigned CANVAS_WIDTH  = 4096,
  parameter int unsigned CANVAS_HEIGHT = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  abr_in_if.sink              px_in_i,
  abr_out_if.source           px_out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t       cfg_q, cfg_d;
  stage_en_t  stage_en;
  pipe_stat_t pipe_stat;
  logic       region_hit;
  logic       in_xfer, out_xfer;

  // --------------------------------------------------------------------------
  // Configuration registers: decode the index, drop writes beyond the list
  // --------------------------------------------------------------------------
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SHAPE:    cfg_d.shape      = shape_e'(cfg_wdata_i[0]);
        CFG_ORIGIN_X: cfg_d.origin_x   = $signed(cfg_wdata_i[13:0]);
        CFG_ORIGIN_Y: cfg_d.origin_y   = $signed(cfg_wdata_i[13:0]);
        CFG_EXTENT_W: cfg_d.extent_w   = cfg_wdata_i[12:0];
        CFG_EXTENT_H: cfg_d.extent_h   = cfg_wdata_i[12:0];
        CFG_RADIUS:   cfg_d.radius     = cfg_wdata_i[11:0];
        CFG_FILL:     cfg_d.fill_color = cfg_wdata_i[23:0];
        CFG_ALPHA:    cfg_d.alpha      = cfg_wdata_i[7:0];
        default:      cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: valid bits travel alongside the datapath stages
  // --------------------------------------------------------------------------
  abr_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (px_in_i.valid),
    .in_ready_o  (px_in_i.ready),
    .out_valid_o (px_out_o.valid),
    .out_ready_i (px_out_o.ready),
    .en_o        (stage_en),
    .stat_o      (pipe_stat)
  );

  // --------------------------------------------------------------------------
  // Region test: rectangle or disc, clipped to the canvas
  // --------------------------------------------------------------------------
  abr_region #(
    .CANVAS_WIDTH  (CANVAS_WIDTH),
    .CANVAS_HEIGHT (CANVAS_HEIGHT)
  ) u_region (
    .clk_i   (clk_i),
    .en_i    (stage_en),
    .cfg_i   (cfg_q),
    .pix_x_i (px_in_i.pix_x),
    .pix_y_i (px_in_i.pix_y),
    .hit_o   (region_hit)
  );

  // --------------------------------------------------------------------------
  // Color blend and output register
  // --------------------------------------------------------------------------
  abr_blend u_blend (
    .clk_i       (clk_i),
    .en_i        (stage_en),
    .cfg_i       (cfg_q),
    .old_pixel_i (px_in_i.old_pixel),
    .hit_i       (region_hit),
    .new_pixel_o (px_out_o.new_pixel),
    .covered_o   (px_out_o.covered)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  assign in_xfer  = px_in_i.valid && px_in_i.ready;
  assign out_xfer = px_out_o.valid && px_out_o.ready;

  // a blended pixel always leaves opaque
  `ABR_ASSERT_IMP(a_covered_opaque, clk_i, rst_ni, px_out_o.valid && px_out_o.covered, px_out_o.new_pixel[31:24] == Opaque, "covered pixel not opaque")
  // without a transfer on either side no pixel appears or vanishes
  `ABR_ASSERT_NXT(a_count_held, clk_i, rst_ni, !in_xfer && !out_xfer, $countones(pipe_stat.vld) == $past($countones(pipe_stat.vld)), "pixel count changed")
  // a full pipeline with a stalled output takes nothing new
  `ABR_ASSERT_IMP(a_full_stall, clk_i, rst_ni, (pipe_stat.vld == 3'b111) && !px_out_o.ready, !px_in_i.ready, "input taken while full and stalled")

endmodule

[bench/alpha_blend_region_test.sv]
// ----------------------------------------------------------------------------
// alpha_blend_region_test
// Self-checking bench for the region alpha blend pixel engine: a queue-fed
// driver streams canvas pixels, a clocked monitor predicts every result
// from a local copy of the configuration and compares it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module alpha_blend_region_test;
  import abr_pkg::*;

  localparam int CanvasW      = 4096;
  localparam int CanvasH      = 4096;
  localparam int ChanMax      = 255;
  localparam int RoundBias    = 127;
  localparam logic [7:0] OpaqueByte = 8'hFF;
  localparam logic [3:0] CfgIdxSpare = 4'd15;  // no register behind this index
  localparam int SettleCycles = 6;             // pipeline is three stages deep
  localparam int LongHold     = 40;
  localparam int ReportMax    = 10;
  localparam int CycleLimit   = 200000;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [31:0] old_pixel;
  } canvas_pix_t;

  typedef struct packed {
    logic [31:0] new_pixel;
    logic        covered;
  } blend_res_t;

  logic clk;
  logic rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  abr_in_if  px_in ();
  abr_out_if px_out ();

  alpha_blend_region #(
    .CANVAS_WIDTH (CanvasW),
    .CANVAS_HEIGHT(CanvasH)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .px_in_i    (px_in),
    .px_out_o   (px_out),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Local copy of the region and paint settings
  cfg_t        cfg_mirror;
  canvas_pix_t pixel_q[$];     // pixels waiting for the driver
  blend_res_t  blend_q[$];     // predicted results in transfer order
  canvas_pix_t cur_pix;
  int pushed_cnt;
  int accepted_cnt;
  int err_cnt;
  int cycle_cnt;
  int send_gap;
  int hold_left;
  int hold_req;
  int hold_seen;
  bit idle_en;
  bit in_taken;
  // Coordinate window around the current region, used to bias stimulus
  int win_x_lo, win_x_hi, win_y_lo, win_y_hi;

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic logic [7:0] mix_channel(logic [7:0] old_c, logic [7:0] fill_c,
                                             logic [7:0] wgt);
    int acc;
    acc = (int'(old_c) * (ChanMax - int'(wgt)) + int'(fill_c) * int'(wgt) + RoundBias)
          / ChanMax;
    return acc[7:0];
  endfunction

  function automatic bit region_hit(int px, int py);
    int ox, oy, w, h, r, dx, dy;
    longint dist2;
    ox = {{18{cfg_mirror.origin_x[13]}}, cfg_mirror.origin_x};
    oy = {{18{cfg_mirror.origin_y[13]}}, cfg_mirror.origin_y};
    w  = {19'd0, cfg_mirror.extent_w};
    h  = {19'd0, cfg_mirror.extent_h};
    r  = {20'd0, cfg_mirror.radius};
    if (px >= CanvasW || py >= CanvasH) return 1'b0;
    if (cfg_mirror.shape == SHAPE_DISC) begin
      dx = px - ox;
      dy = py - oy;
      dist2 = longint'(dx) * dx + longint'(dy) * dy;
      return dist2 <= longint'(r) * r;
    end
    if (w == 0 || h == 0) return 1'b0;
    return px >= ox && px < ox + w && py >= oy && py < oy + h;
  endfunction

  function automatic blend_res_t blend_predict(canvas_pix_t p);
    blend_res_t res;
    if (region_hit({20'd0, p.x}, {20'd0, p.y})) begin
      res.new_pixel = {OpaqueByte,
                       mix_channel(p.old_pixel[23:16], cfg_mirror.fill_color[23:16],
                                   cfg_mirror.alpha),
                       mix_channel(p.old_pixel[15:8], cfg_mirror.fill_color[15:8],
                                   cfg_mirror.alpha),
                       mix_channel(p.old_pixel[7:0], cfg_mirror.fill_color[7:0],
                                   cfg_mirror.alpha)};
      res.covered = 1'b1;
    end else begin
      res.new_pixel = p.old_pixel;
      res.covered   = 1'b0;
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offer queued pixels at the falling edge, with random gaps
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_ni) begin
      // Hold the current pixel until its transfer has been seen
      if (!px_in.valid || in_taken) begin
        if (send_gap > 0) begin
          send_gap--;
          px_in.valid <= 1'b0;
        end else if (pixel_q.size() == 0) begin
          px_in.valid <= 1'b0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 4);
          px_in.valid <= 1'b0;
        end else begin
          cur_pix = pixel_q.pop_front();
          px_in.valid     <= 1'b1;
          px_in.pix_x     <= cur_pix.x;
          px_in.pix_y     <= cur_pix.y;
          px_in.old_pixel <= cur_pix.old_pixel;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts plus one long hold-off on request
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_ni) begin
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        px_out.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(0, 4);
        px_out.ready <= 1'b0;
      end else begin
        px_out.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check result transfers, then predict for input transfers
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    blend_res_t want;
    canvas_pix_t seen;
    cycle_cnt++;
    if (rst_ni && px_out.valid && px_out.ready) begin
      if (blend_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= ReportMax)
          $display("%0t: unexpected result new_pixel=%h covered=%b", $realtime,
                   px_out.new_pixel, px_out.covered);
      end else begin
        want = blend_q.pop_front();
        if (px_out.new_pixel !== want.new_pixel || px_out.covered !== want.covered) begin
          err_cnt++;
          if (err_cnt <= ReportMax)
            $display("%0t: mismatch new_pixel exp=%h act=%h covered exp=%b act=%b",
                     $realtime, want.new_pixel, px_out.new_pixel, want.covered,
                     px_out.covered);
        end
      end
    end
    in_taken = rst_ni && px_in.valid && px_in.ready;
    if (in_taken) begin
      seen.x         = px_in.pix_x;
      seen.y         = px_in.pix_y;
      seen.old_pixel = px_in.old_pixel;
      blend_q.push_back(blend_predict(seen));
      accepted_cnt++;
    end
  end

  // Watchdog: a stuck handshake ends the run here
  always @(posedge clk) begin
    if (cycle_cnt == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Configuration and stimulus helpers
  // --------------------------------------------------------------------------
  task automatic write_reg(logic [3:0] idx, logic [23:0] val);
    @(negedge clk);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_SHAPE:    cfg_mirror.shape      = shape_e'(val[0]);
      CFG_ORIGIN_X: cfg_mirror.origin_x   = val[13:0];
      CFG_ORIGIN_Y: cfg_mirror.origin_y   = val[13:0];
      CFG_EXTENT_W: cfg_mirror.extent_w   = val[12:0];
      CFG_EXTENT_H: cfg_mirror.extent_h   = val[12:0];
      CFG_RADIUS:   cfg_mirror.radius     = val[11:0];
      CFG_FILL:     cfg_mirror.fill_color = val;
      CFG_ALPHA:    cfg_mirror.alpha      = val[7:0];
      default: ;    // unused index: the block must ignore it
    endcase
    @(negedge clk);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_rect(int ox, int oy, int w, int h);
    write_reg(CFG_SHAPE, 24'(SHAPE_RECT));
    write_reg(CFG_ORIGIN_X, 24'(ox));
    write_reg(CFG_ORIGIN_Y, 24'(oy));
    write_reg(CFG_EXTENT_W, 24'(w));
    write_reg(CFG_EXTENT_H, 24'(h));
    win_x_lo = ox - 3;
    win_x_hi = ox + w + 3;
    win_y_lo = oy - 3;
    win_y_hi = oy + h + 3;
  endtask

  task automatic set_disc(int cx, int cy, int r);
    write_reg(CFG_SHAPE, 24'(SHAPE_DISC));
    write_reg(CFG_ORIGIN_X, 24'(cx));
    write_reg(CFG_ORIGIN_Y, 24'(cy));
    write_reg(CFG_RADIUS, 24'(r));
    win_x_lo = cx - r - 3;
    win_x_hi = cx + r + 3;
    win_y_lo = cy - r - 3;
    win_y_hi = cy + r + 3;
  endtask

  task automatic set_paint(logic [23:0] fill, logic [7:0] wgt);
    write_reg(CFG_FILL, fill);
    write_reg(CFG_ALPHA, {16'd0, wgt});
  endtask

  task automatic push_pixel(int x, int y, logic [31:0] old_pixel);
    canvas_pix_t p;
    p.x = x[11:0];
    p.y = y[11:0];
    p.old_pixel = old_pixel;
    pixel_q.push_back(p);
    pushed_cnt++;
  endtask

  // Mostly in a window around the region, sometimes anywhere on the canvas
  function automatic int pick_coord(int lo, int hi);
    int v;
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, CanvasW - 1);
    v = lo + int'($urandom_range(0, hi - lo));
    if (v < 0) v = 0;
    if (v > CanvasW - 1) v = CanvasW - 1;
    return v;
  endfunction

  task automatic push_random(int n);
    for (int i = 0; i < n; i++)
      push_pixel(pick_coord(win_x_lo, win_x_hi), pick_coord(win_y_lo, win_y_hi), $urandom());
  endtask

  function automatic logic [7:0] pick_alpha();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int pick_origin();
    case ($urandom_range(0, 9))
      0:       return -8192;
      1:       return 8191;
      2:       return $urandom_range(0, 16383) - 8192;
      default: return $urandom_range(0, 4400) - 200;
    endcase
  endfunction

  function automatic int pick_size(int top);
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return top;
      default: return $urandom_range(1, 200);
    endcase
  endfunction

  // Wait for every transfer and result, then let the pipeline settle
  task automatic drain();
    while (accepted_cnt != pushed_cnt || blend_q.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic random_config(int phase);
    case (phase)
      // Rectangle ending just left of and above the canvas: nothing drawn
      0: begin
        set_rect(-8192, -8192, 8191, 8191);
        set_paint(24'($urandom()), pick_alpha());
      end
      // Widest rectangle from the corner, full fill
      1: begin
        set_rect(0, 0, 8191, 8191);
        set_paint(24'hFFFFFF, 8'd255);
      end
      // Largest disc over the canvas middle, alpha zero
      2: begin
        set_disc(2048, 2048, 4095);
        set_paint(24'($urandom()), 8'd0);
      end
      // Largest disc centered far off the canvas
      3: begin
        set_disc(8191, -8192, 4095);
        set_paint(24'h000000, 8'd255);
      end
      default: begin
        if ($urandom_range(0, 1) == 0) begin
          set_rect(pick_origin(), pick_origin(), pick_size(8191), pick_size(8191));
          write_reg(CFG_RADIUS, 24'($urandom_range(0, 4095)));
        end else begin
          write_reg(CFG_EXTENT_W, 24'($urandom_range(0, 8191)));
          write_reg(CFG_EXTENT_H, 24'($urandom_range(0, 8191)));
          set_disc(pick_origin(), pick_origin(), pick_size(4095));
        end
        set_paint(24'($urandom()), pick_alpha());
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_SHAPE;
    cfg_wdata_i     = '0;
    px_in.valid     = 1'b0;
    px_in.pix_x     = '0;
    px_in.pix_y     = '0;
    px_in.old_pixel = '0;
    px_out.ready    = 1'b0;
    cfg_mirror      = '0;
    pushed_cnt = 0;
    accepted_cnt = 0;
    err_cnt = 0;
    cycle_cnt = 0;
    send_gap = 0;
    hold_left = 0;
    hold_req = 0;
    hold_seen = 0;
    idle_en = 1'b1;
    in_taken = 1'b0;
    win_x_lo = 0;
    win_x_hi = 8;
    win_y_lo = 0;
    win_y_hi = 8;
    repeat (6) @(negedge clk);
    rst_ni = 1'b1;

    // Registers straight out of reset: empty rectangle, nothing covered
    push_pixel(0, 0, 32'h12345678);
    push_pixel(4095, 4095, 32'hFFFFFFFF);
    drain();

    // A write to an index without a register must change nothing
    write_reg(CfgIdxSpare, 24'hFFFFFF);
    push_pixel(0, 0, 32'h00000000);
    drain();

    // Rectangle edges: left/right and top/bottom, inclusive vs exclusive
    set_rect(10, 20, 5, 3);
    set_paint(24'hFF8000, 8'd128);
    push_pixel(9, 20, 32'h01020304);
    push_pixel(10, 20, 32'h01020304);
    push_pixel(14, 22, 32'h80808080);
    push_pixel(15, 20, 32'h80808080);
    push_pixel(10, 23, 32'h00FFFFFF);
    push_pixel(10, 19, 32'h00FFFFFF);
    push_pixel(12, 21, 32'h00000000);
    push_pixel(12, 21, 32'hFFFFFFFF);
    drain();

    // Alpha zero keeps RGB but still forces the alpha byte opaque
    set_paint(24'h00FF00, 8'd0);
    push_pixel(12, 21, 32'h00ABCDEF);
    drain();
    set_paint(24'hFFFFFF, 8'd255);
    push_pixel(11, 20, 32'h00000000);
    push_pixel(11, 20, 32'h7F7F7F7F);
    drain();

    // Zero radius covers the centre only; then a small disc boundary
    set_disc(100, 100, 0);
    push_pixel(100, 100, 32'h00102030);
    push_pixel(101, 100, 32'h00102030);
    push_pixel(100, 99, 32'h00102030);
    drain();
    write_reg(CFG_RADIUS, 24'd5);
    push_pixel(105, 100, 32'hC0FFEE00);
    push_pixel(104, 103, 32'hC0FFEE00);
    push_pixel(104, 104, 32'hC0FFEE00);
    push_pixel(95, 100, 32'hC0FFEE00);
    drain();

    // Random phases, each under a fresh configuration
    for (int phase = 0; phase < 8; phase++) begin
      random_config(phase);
      // Long receiver hold-off while the sender keeps offering pixels
      if (phase == 4) hold_req++;
      push_random(90);
      drain();
    end

    // Closing stretch at full rate on both sides
    idle_en = 1'b0;
    random_config(8);
    push_random(130);
    drain();

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
